@@ rtl/lcec_pkg.sv @@
`timescale 1ns / 1ps

package lcec_pkg;

   localparam int MAX_FEATURES = 1024;
   localparam int ADDR_W       = $clog2(MAX_FEATURES);
   localparam int COUNT_W      = 11;
   localparam int VALUE_W      = 16;
   localparam int ACC_W        = 48;
   localparam int TALLY_W      = 32;
   localparam int RATE_W       = 16;
   localparam int OP_W         = 2;
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 88;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_FEATURE = 2'd1,
      OP_REPORT  = 2'd2
   } op_type;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   typedef struct packed {
      logic start;
      logic clear;
   } mac_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [ACC_W-1:0] acc;
   } mac_status_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_status_type;

endpackage

@@ rtl/lcec_ram.sv @@
`timescale 1ns / 1ps

module lcec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lcec_mac.sv @@
`timescale 1ns / 1ps

module lcec_mac
   import lcec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  mac_ctrl_type        ctrl,
   input  logic [VALUE_W-1:0]  weight,
   input  logic [VALUE_W-1:0]  feature,
   output mac_status_type      status
);

   localparam int CNT_W = $clog2(VALUE_W);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [VALUE_W-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               last_step;
   logic [ACC_W-1:0]   sum;

   // The top multiplier bit carries negative weight in two's complement.
   assign last_step = (cnt_ff == CNT_W'(VALUE_W - 1));
   assign sum       = last_step ? (acc_ff - mcand_ff) : (acc_ff + mcand_ff);

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end
      if (ctrl.start) begin
         mcand_in  = {{(ACC_W - VALUE_W){weight[VALUE_W-1]}}, weight};
         mplier_in = feature;
         cnt_in    = '0;
         busy_in   = 1'b1;
         done_in   = 1'b0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = sum;
         end
         mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[VALUE_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign status.done = done_ff;
   assign status.acc  = acc_ff;

endmodule

@@ rtl/lcec_div.sv @@
`timescale 1ns / 1ps

module lcec_div
   import lcec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TALLY_W-1:0] dividend,
   input  logic [TALLY_W-1:0] divisor,
   output div_status_type     status
);

   localparam int CNT_W = $clog2(RATE_W);

   logic [TALLY_W-1:0] rem_ff, rem_in;
   logic [TALLY_W-1:0] dvsr_ff, dvsr_in;
   logic [RATE_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [TALLY_W:0]   shifted;
   logic [TALLY_W:0]   diff;
   logic               fits;

   // The error tally never exceeds the sample tally, so the partial
   // remainder always stays below the divisor.
   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, dvsr_ff};
   assign fits    = (shifted >= {1'b0, dvsr_ff});

   always_comb begin
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvsr_in = divisor;
         rem_in  = dividend;
         cnt_in  = '0;
         quo_in  = '0;
         if (divisor == '0) begin
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (dividend == divisor) begin
            quo_in  = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            done_in = 1'b0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[TALLY_W-1:0] : shifted[TALLY_W-1:0];
         quo_in = {quo_ff[RATE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RATE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

@@ rtl/linear_classifier_error_counter_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Transfer when              Payload
// req       in         req_tvalid & req_tready    tuser: operation; tdata: index, value, label
// rsp       out        rsp_tvalid & rsp_tready    tuser: kind; tdata: verdict and tally fields
// csr       in         csr_wr_en                  feature_count
//
// A weight load is written in the accepting cycle. A feature reads the weight
// store in the accepting cycle, loads the multiplier in S_READ, runs the
// bit-serial multiply-accumulate and closes the item in S_MAC; the last
// feature of a sample adds S_VERDICT to issue the verdict. A report runs the
// 16-step restoring divider, skipped for a zero divisor or equal operands.
// Reset is synchronous; the weight store is not cleared and needs no sweep.
// A stalled result waits in the output register; an item that produces a
// result holds in its final step until that register is free.

module linear_classifier_error_counter_core
   import lcec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // weight_index, value, label, zero pad
   input  logic [OP_W-1:0]       req_tuser,  // operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // prediction, mismatch, errors_so_far,
                                             // samples_so_far, error_rate, no_samples, pad
   output logic                  rsp_tuser,  // kind
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MAC,
      S_VERDICT,
      S_DIV,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic [4:0]         pad;
      logic               no_samples;
      logic [RATE_W-1:0]  error_rate;
      logic [TALLY_W-1:0] samples_so_far;
      logic [TALLY_W-1:0] errors_so_far;
      logic               mismatch;
      logic               prediction;
   } rsp_data_type;

   state_type          state_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [ADDR_W-1:0]  pos_ff;
   logic [TALLY_W-1:0] err_ff;
   logic [TALLY_W-1:0] smp_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               label_ff;
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   rsp_data_type       rsp_data_ff;

   logic [ADDR_W-1:0]  req_index;
   logic [VALUE_W-1:0] req_value;
   logic               req_label;
   op_type             req_op;
   logic               accept;
   logic               out_free;
   logic [COUNT_W-1:0] count_eff;
   logic               last_feature;
   logic               pred;
   logic               mis;
   logic [TALLY_W-1:0] smp_next;
   logic [TALLY_W-1:0] err_next;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [VALUE_W-1:0] weight;
   mac_ctrl_type       mac_ctrl;
   mac_status_type     mac_status;
   logic               div_start;
   div_status_type     div_status;

   assign req_index = req_tdata[ADDR_W-1:0];
   assign req_value = req_tdata[ADDR_W+VALUE_W-1:ADDR_W];
   assign req_label = req_tdata[ADDR_W+VALUE_W];
   assign req_op    = op_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign count_eff = (count_ff == '0) ? COUNT_W'(1) :
                      (count_ff > COUNT_W'(MAX_FEATURES)) ? COUNT_W'(MAX_FEATURES) :
                      count_ff;
   assign last_feature = ((COUNT_W'(pos_ff) + COUNT_W'(1)) >= count_eff);

   assign pred     = (mac_status.acc != '0) && !mac_status.acc[ACC_W-1];
   assign mis      = (pred != label_ff);
   assign smp_next = (smp_ff == '1) ? smp_ff : smp_ff + 1'b1;
   assign err_next = (mis && err_ff != '1) ? err_ff + 1'b1 : err_ff;

   assign ram_wr_en = accept && (req_op == OP_LOAD);
   assign ram_rd_en = accept && (req_op == OP_FEATURE);
   assign div_start = accept && (req_op == OP_REPORT);

   assign mac_ctrl.start = (state_ff == S_READ);
   assign mac_ctrl.clear = (state_ff == S_VERDICT) && out_free;

   lcec_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_FEATURES)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_index),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (weight)
   );

   lcec_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .weight  (weight),
      .feature (value_ff),
      .status  (mac_status)
   );

   lcec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (err_ff),
      .divisor  (smp_ff),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= COUNT_W'(MAX_FEATURES);
         pos_ff       <= '0;
         err_ff       <= '0;
         smp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (((state_ff == S_VERDICT) || (state_ff == S_REPORT)) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_op)
                     OP_FEATURE: state_ff <= S_READ;
                     OP_REPORT:  state_ff <= S_DIV;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (mac_status.done) begin
                  if (last_feature) begin
                     state_ff <= S_VERDICT;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_VERDICT: begin
               if (out_free) begin
                  smp_ff   <= smp_next;
                  err_ff   <= err_next;
                  pos_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               if (div_status.done) begin
                  state_ff <= S_REPORT;
               end
            end
            S_REPORT: begin
               if (out_free) begin
                  err_ff   <= '0;
                  smp_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= req_value;
         label_ff <= req_label;
      end
      if (state_ff == S_VERDICT && out_free) begin
         rsp_kind_ff                <= KIND_VERDICT;
         rsp_data_ff.pad            <= '0;
         rsp_data_ff.prediction     <= pred;
         rsp_data_ff.mismatch       <= mis;
         rsp_data_ff.errors_so_far  <= err_next;
         rsp_data_ff.samples_so_far <= smp_next;
         rsp_data_ff.error_rate     <= '0;
         rsp_data_ff.no_samples     <= 1'b0;
      end else if (state_ff == S_REPORT && out_free) begin
         rsp_kind_ff                <= KIND_REPORT;
         rsp_data_ff.pad            <= '0;
         rsp_data_ff.prediction     <= 1'b0;
         rsp_data_ff.mismatch       <= 1'b0;
         rsp_data_ff.errors_so_far  <= err_ff;
         rsp_data_ff.samples_so_far <= smp_ff;
         rsp_data_ff.error_rate     <= div_status.quotient;
         rsp_data_ff.no_samples     <= (smp_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_errors_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data_ff.errors_so_far <= rsp_data_ff.samples_so_far))
      else $error("error tally exceeds sample tally");

   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_REPORT) |->
         (rsp_data_ff.no_samples == (rsp_data_ff.samples_so_far == '0)))
      else $error("empty flag disagrees with sample tally");

   a_empty_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.no_samples) |-> (rsp_data_ff.error_rate == '0))
      else $error("empty report carries a nonzero rate");

   a_report_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPORT && out_free) |=> (err_ff == '0 && smp_ff == '0))
      else $error("tallies not cleared after report");

endmodule

@@ tb/sv/linear_classifier_error_counter_core_test.sv @@
`timescale 1ns / 1ps

module linear_classifier_error_counter_core_test;
   import lcec_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int MAX_REPORTED  = 40;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [ADDR_W-1:0]  index;
      logic [VALUE_W-1:0] value;
      logic               label;
   } request_type;

   typedef struct {
      logic               kind;
      logic               prediction;
      logic               mismatch;
      logic [TALLY_W-1:0] errors;
      logic [TALLY_W-1:0] samples;
      logic [RATE_W-1:0]  rate;
      logic               empty;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]    csr_wr_data = '0;

   linear_classifier_error_counter_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type req_backlog[$];
   outcome_type awaited_outcomes[$];
   int       mismatch_count = 0;
   int       hold_requests = 0;
   int       cycle_count = 0;

   // Classifier state as seen from the accepted transfers.
   logic signed [VALUE_W-1:0] weight_model[MAX_FEATURES];
   logic [ACC_W-1:0]          dot_model = '0;
   int unsigned               position_model = 0;
   logic [TALLY_W-1:0]        error_model = '0;
   logic [TALLY_W-1:0]        sample_model = '0;
   logic [COUNT_W-1:0]        count_model = COUNT_W'(MAX_FEATURES);

   // Stimulus side bookkeeping of which weights hold defined values.
   bit loaded[MAX_FEATURES];
   int loaded_prefix = 0;

   task automatic classify_item(input request_type r);
      int unsigned        n;
      int unsigned        p;
      logic signed [31:0] product;
      logic [63:0]        quotient;
      outcome_type        o;
      o = '{default: '0};
      case (r.op)
         OP_LOAD: begin
            weight_model[r.index] = r.value;
         end
         OP_FEATURE: begin
            n = (count_model == 0) ? 1 :
                (count_model > MAX_FEATURES) ? MAX_FEATURES : count_model;
            p = (position_model >= MAX_FEATURES) ? MAX_FEATURES - 1 : position_model;
            product = $signed(r.value) * weight_model[p];
            dot_model = dot_model + {{(ACC_W - 32){product[31]}}, product};
            if (position_model + 1 >= n) begin
               o.kind       = KIND_VERDICT;
               o.prediction = (dot_model != '0) && !dot_model[ACC_W-1];
               o.mismatch   = (o.prediction != r.label);
               if (sample_model != '1) sample_model = sample_model + 1;
               if (o.mismatch && error_model != '1) error_model = error_model + 1;
               o.errors  = error_model;
               o.samples = sample_model;
               dot_model = '0;
               position_model = 0;
               awaited_outcomes.push_back(o);
            end else begin
               position_model = position_model + 1;
            end
         end
         OP_REPORT: begin
            o.kind    = KIND_REPORT;
            o.errors  = error_model;
            o.samples = sample_model;
            if (sample_model == '0) begin
               o.empty = 1'b1;
            end else begin
               quotient = {16'b0, error_model, 16'b0} / {32'b0, sample_model};
               o.rate = (quotient > 64'd65535) ? 16'hFFFF : quotient[RATE_W-1:0];
            end
            error_model  = '0;
            sample_model = '0;
            awaited_outcomes.push_back(o);
         end
         default: begin
         end
      endcase
   endtask

   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      request_type taken;
      request_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            taken.op    = req_tuser;
            taken.index = req_tdata[ADDR_W-1:0];
            taken.value = req_tdata[ADDR_W +: VALUE_W];
            taken.label = req_tdata[ADDR_W + VALUE_W];
            classify_item(taken);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               next_item = req_backlog.pop_front();
               req_tuser  <= next_item.op;
               req_tdata  <= {5'b0, next_item.label, next_item.value, next_item.index};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input logic [TALLY_W-1:0] want,
                                input logic [TALLY_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_outcome();
      outcome_type want;
      if (awaited_outcomes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTED)
            $display("%0t ns: unexpected result transfer, expected none, actual kind %0d",
                     $time, rsp_tuser);
      end else begin
         want = awaited_outcomes.pop_front();
         compare_field("kind", want.kind, rsp_tuser);
         compare_field("prediction", want.prediction, rsp_tdata[0]);
         compare_field("mismatch", want.mismatch, rsp_tdata[1]);
         compare_field("errors_so_far", want.errors, rsp_tdata[33:2]);
         compare_field("samples_so_far", want.samples, rsp_tdata[65:34]);
         compare_field("error_rate", want.rate, rsp_tdata[81:66]);
         compare_field("no_samples", want.empty, rsp_tdata[82]);
      end
   endtask

   int holds_served = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_outcome();
         if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left = mode_left - 1;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 11))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   task automatic enqueue(input logic [OP_W-1:0] op, input int index,
                          input logic [VALUE_W-1:0] value, input logic label);
      request_type r;
      r.op    = op;
      r.index = ADDR_W'(index);
      r.value = value;
      r.label = label;
      req_backlog.push_back(r);
      if (op == OP_LOAD) begin
         loaded[r.index] = 1'b1;
         while (loaded_prefix < MAX_FEATURES && loaded[loaded_prefix])
            loaded_prefix++;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || awaited_outcomes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_feature_count(input logic [COUNT_W-1:0] count);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      count_model = count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random_phase(input int items, input bit long_hold);
      int usable;
      int pick;
      int top;
      usable = (loaded_prefix < 48) ? loaded_prefix : 48;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         program_feature_count('0);
      else if (pick == 1)
         program_feature_count(COUNT_W'(usable));
      else
         program_feature_count(COUNT_W'($urandom_range(1, (usable < 8) ? usable : 8)));
      if (long_hold) hold_requests++;
      top = (loaded_prefix < MAX_FEATURES) ? loaded_prefix : MAX_FEATURES - 1;
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            enqueue(OP_FEATURE, $urandom, random_value(), 1'($urandom));
         else if (pick < 84)
            enqueue(OP_LOAD, $urandom_range(0, 1) ? $urandom_range(0, top) : $urandom,
                    random_value(), 1'($urandom));
         else if (pick < 95)
            enqueue(OP_REPORT, $urandom, random_value(), 1'($urandom));
         else
            enqueue(OP_UNUSED, $urandom, random_value(), 1'($urandom));
      end
   endtask

   initial begin
      int extra;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty report right after reset, and the unused operation.
      enqueue(OP_REPORT, 0, 16'h0000, 1'b0);
      enqueue(OP_UNUSED, $urandom, random_value(), 1'b1);
      enqueue(OP_LOAD, 0, 16'h7FFF, 1'b0);
      enqueue(OP_LOAD, MAX_FEATURES - 1, 16'h8000, 1'b1);
      enqueue(OP_LOAD, 1, 16'h1234, 1'b0);
      enqueue(OP_LOAD, 2, 16'hFFFF, 1'b0);

      // A count of zero behaves as one feature per sample.
      program_feature_count('0);
      enqueue(OP_FEATURE, $urandom, 16'h7FFF, 1'b0);
      enqueue(OP_FEATURE, $urandom, 16'h8000, 1'b0);
      enqueue(OP_FEATURE, $urandom, 16'h0000, 1'b1);
      enqueue(OP_REPORT, $urandom, 16'h0000, 1'b0);
      enqueue(OP_FEATURE, $urandom, 16'h7FFF, 1'b0);
      enqueue(OP_REPORT, $urandom, 16'h0000, 1'b0);
      enqueue(OP_LOAD, 0, 16'h8000, 1'b0);
      enqueue(OP_FEATURE, $urandom, 16'h8000, 1'b1);

      // A report in the middle of a sample leaves the partial sum alone.
      program_feature_count(11'd3);
      enqueue(OP_FEATURE, $urandom, 16'h4000, 1'b1);
      enqueue(OP_REPORT, $urandom, 16'h0000, 1'b0);
      enqueue(OP_FEATURE, $urandom, 16'hC000, 1'b1);
      enqueue(OP_FEATURE, $urandom, 16'h0101, 1'b0);

      // Lowering the count mid-sample ends the sample on the next feature.
      enqueue(OP_FEATURE, $urandom, 16'h2345, 1'b0);
      program_feature_count(11'd1);
      enqueue(OP_FEATURE, $urandom, 16'h7654, 1'b1);

      for (int i = 3; i < 24; i++)
         enqueue(OP_LOAD, i, random_value(), 1'($urandom));
      for (int phase = 0; phase < 20; phase++)
         run_random_phase(50, phase == 4);

      // A count above the maximum keeps the sample open over loaded weights,
      // then a lowered count ends it.
      program_feature_count('1);
      extra = loaded_prefix - int'(position_model) - 1;
      if (extra > 16) extra = 16;
      repeat (extra)
         enqueue(OP_FEATURE, $urandom, random_value(), 1'($urandom));
      program_feature_count(11'd1);
      enqueue(OP_FEATURE, $urandom, random_value(), 1'($urandom));
      enqueue(OP_REPORT, $urandom, random_value(), 1'($urandom));

      wait_idle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
